// File: rtl/rigid_body_euler_step_defines.svh
// Assertion helpers for the block's modules; only the sequencer includes them.
`ifndef RIGID_BODY_EULER_STEP_DEFINES_SVH
`define RIGID_BODY_EULER_STEP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition leads to an outcome in the following cycle.
`define RBE_ASSERT_NEXT(label, pre, post, msg) \
  `RBE_ASSERT(label, (pre) |=> (post), msg)

`endif

// File: rtl/rbe_pkg.sv
`timescale 1ns / 1ps

package rbe_pkg;

  localparam int unsigned WORD_BITS_DEF     = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned TS_BITS   = 16;
  localparam int unsigned GS_BITS   = 16;
  localparam int unsigned DRAG_BITS = 16;
  localparam int unsigned IM_BITS   = 24;

  localparam int unsigned TS_FRAC   = 16;
  localparam int unsigned GS_FRAC   = 8;
  localparam int unsigned IM_FRAC   = 16;
  localparam int unsigned DRAG_FRAC = 8;
  localparam int unsigned DF_FRAC   = DRAG_FRAC + TS_FRAC;
  localparam int unsigned DF_BITS   = DF_FRAC + 1;
  localparam int unsigned COEF_BITS = DF_BITS + 1;

  localparam int unsigned CFG_IDX_BITS = 4;
  localparam int unsigned PC_BITS      = 5;

  localparam logic [TS_BITS-1:0]          TS_RST       = 16'd1092;
  localparam logic signed [GS_BITS-1:0]   GS_RST       = 16'sd256;
  localparam logic [IM_BITS-1:0]          IM_RST       = 24'd65536;
  localparam logic [63:0]                 GRAV_Y_UNITS = 64'd980;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FORCE   = 2'd1,
    CMD_IMPULSE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TIME_STEP  = 4'd0,
    REG_GRAVITY_X  = 4'd1,
    REG_GRAVITY_Y  = 4'd2,
    REG_GRAV_SCALE = 4'd3,
    REG_GRAVITY_ON = 4'd4,
    REG_KINEMATIC  = 4'd5,
    REG_DRAG_RATE  = 4'd6,
    REG_INV_MASS   = 4'd7
  } reg_idx_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef enum logic [2:0] {
    SRC_VEC_X,
    SRC_VEC_Y,
    SRC_GRAV_X,
    SRC_GRAV_Y,
    SRC_ACC_X,
    SRC_ACC_Y,
    SRC_VEL_X,
    SRC_VEL_Y
  } src_e;

  typedef enum logic [1:0] {
    COEF_INV_MASS,
    COEF_GRAV_SCALE,
    COEF_TIME_STEP,
    COEF_DRAG
  } coef_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_MOVE
  } wr_e;

  typedef enum logic [2:0] {
    DST_VEC_X,
    DST_VEC_Y,
    DST_ACC_X,
    DST_ACC_Y,
    DST_VEL_X,
    DST_VEL_Y,
    DST_POS_X,
    DST_POS_Y
  } dst_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_TICK,
    COND_IGNORE_VEC,
    COND_KINEMATIC,
    COND_NO_GRAV,
    COND_NO_DRAG
  } cond_e;

  typedef struct packed {
    logic gravity_on;
    logic kinematic;
    logic drag_on;
    logic mass_zero;
  } cfg_flags_t;

  typedef struct packed {
    logic               mul_en;
    src_e               src;
    coef_e              coef;
    wr_e                wr;
    dst_e               dst;
    logic               clr_acc;
    logic               emit;
    logic               last;
    cond_e              cond;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    src_e  src;
    coef_e coef;
    wr_e   wr;
    dst_e  dst;
    logic  clr_acc;
    logic  emit;
  } ctrl_t;

  localparam logic [PC_BITS-1:0] PC_TICK = 5'd5;
  localparam logic [PC_BITS-1:0] PC_VEL  = 5'd10;
  localparam logic [PC_BITS-1:0] PC_POS  = 5'd16;
  localparam logic [PC_BITS-1:0] PC_EMIT = 5'd19;
  localparam logic [PC_BITS-1:0] PC_END  = 5'd20;

  function automatic ucode_t ucode_word(logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      5'd0: begin
        w.cond = COND_TICK;  w.target = PC_TICK;
      end
      5'd1: begin
        w.cond = COND_IGNORE_VEC;  w.target = PC_END;
      end
      5'd2: begin
        w.mul_en = 1'b1;  w.src = SRC_VEC_X;  w.coef = COEF_INV_MASS;
      end
      5'd3: begin
        w.mul_en = 1'b1;  w.src = SRC_VEC_Y;  w.coef = COEF_INV_MASS;
        w.wr = WR_ADD;  w.dst = DST_VEC_X;
      end
      5'd4: begin
        w.wr = WR_ADD;  w.dst = DST_VEC_Y;  w.last = 1'b1;
      end
      5'd5: begin
        w.cond = COND_KINEMATIC;  w.target = PC_EMIT;
      end
      5'd6: begin
        w.cond = COND_NO_GRAV;  w.target = PC_VEL;
      end
      5'd7: begin
        w.mul_en = 1'b1;  w.src = SRC_GRAV_X;  w.coef = COEF_GRAV_SCALE;
      end
      5'd8: begin
        w.mul_en = 1'b1;  w.src = SRC_GRAV_Y;  w.coef = COEF_GRAV_SCALE;
        w.wr = WR_ADD;  w.dst = DST_ACC_X;
      end
      5'd9: begin
        w.wr = WR_ADD;  w.dst = DST_ACC_Y;
      end
      5'd10: begin
        w.mul_en = 1'b1;  w.src = SRC_ACC_X;  w.coef = COEF_TIME_STEP;
      end
      5'd11: begin
        w.mul_en = 1'b1;  w.src = SRC_ACC_Y;  w.coef = COEF_TIME_STEP;
        w.wr = WR_ADD;  w.dst = DST_VEL_X;
      end
      5'd12: begin
        w.wr = WR_ADD;  w.dst = DST_VEL_Y;
        w.cond = COND_NO_DRAG;  w.target = PC_POS;
      end
      5'd13: begin
        w.mul_en = 1'b1;  w.src = SRC_VEL_X;  w.coef = COEF_DRAG;
      end
      5'd14: begin
        w.mul_en = 1'b1;  w.src = SRC_VEL_Y;  w.coef = COEF_DRAG;
        w.wr = WR_MOVE;  w.dst = DST_VEL_X;
      end
      5'd15: begin
        w.wr = WR_MOVE;  w.dst = DST_VEL_Y;
      end
      5'd16: begin
        w.mul_en = 1'b1;  w.src = SRC_VEL_X;  w.coef = COEF_TIME_STEP;
      end
      5'd17: begin
        w.mul_en = 1'b1;  w.src = SRC_VEL_Y;  w.coef = COEF_TIME_STEP;
        w.wr = WR_ADD;  w.dst = DST_POS_X;
      end
      5'd18: begin
        w.wr = WR_ADD;  w.dst = DST_POS_Y;  w.clr_acc = 1'b1;
      end
      5'd19: begin
        w.emit = 1'b1;  w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/rbe_cfg_regs.sv
`timescale 1ns / 1ps

module rbe_cfg_regs #(
  parameter int unsigned WORD_BITS     = rbe_pkg::WORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rbe_pkg::FRACTION_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [rbe_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [WORD_BITS-1:0]                    cfg_data_i,
  output rbe_pkg::cfg_flags_t                     flags_o,
  output logic [rbe_pkg::TS_BITS-1:0]             time_step_o,
  output logic signed [WORD_BITS-1:0]             grav_x_o,
  output logic signed [WORD_BITS-1:0]             grav_y_o,
  output logic signed [rbe_pkg::GS_BITS-1:0]      grav_scale_o,
  output logic [rbe_pkg::IM_BITS-1:0]             inv_mass_o,
  output logic [rbe_pkg::DF_BITS-1:0]             factor_o
);

  localparam logic [63:0] GRAV_Y_WIDE = rbe_pkg::GRAV_Y_UNITS << FRACTION_BITS;
  localparam logic signed [WORD_BITS-1:0] GRAV_Y_RST = $signed(GRAV_Y_WIDE[WORD_BITS-1:0]);
  localparam logic [rbe_pkg::DF_BITS-1:0] FACTOR_ONE = rbe_pkg::DF_BITS'(1) << rbe_pkg::DF_FRAC;

  logic [rbe_pkg::TS_BITS-1:0]        time_step_q;
  logic signed [WORD_BITS-1:0]        grav_x_q;
  logic signed [WORD_BITS-1:0]        grav_y_q;
  logic signed [rbe_pkg::GS_BITS-1:0] grav_scale_q;
  logic                               gravity_on_q;
  logic                               kinematic_q;
  logic [rbe_pkg::DRAG_BITS-1:0]      drag_q;
  logic [rbe_pkg::IM_BITS-1:0]        inv_mass_q;
  logic [rbe_pkg::DF_BITS-1:0]        factor_q;
  logic [rbe_pkg::DF_BITS-1:0]        factor_d;
  logic [31:0]                        drag_ts;
  logic [32:0]                        factor_diff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q  <= rbe_pkg::TS_RST;
      grav_x_q     <= '0;
      grav_y_q     <= GRAV_Y_RST;
      grav_scale_q <= rbe_pkg::GS_RST;
      gravity_on_q <= 1'b1;
      kinematic_q  <= 1'b0;
      drag_q       <= '0;
      inv_mass_q   <= rbe_pkg::IM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rbe_pkg::reg_idx_e'(cfg_index_i))
        rbe_pkg::REG_TIME_STEP:  time_step_q  <= cfg_data_i[rbe_pkg::TS_BITS-1:0];
        rbe_pkg::REG_GRAVITY_X:  grav_x_q     <= $signed(cfg_data_i);
        rbe_pkg::REG_GRAVITY_Y:  grav_y_q     <= $signed(cfg_data_i);
        rbe_pkg::REG_GRAV_SCALE: grav_scale_q <= $signed(cfg_data_i[rbe_pkg::GS_BITS-1:0]);
        rbe_pkg::REG_GRAVITY_ON: gravity_on_q <= cfg_data_i[0];
        rbe_pkg::REG_KINEMATIC:  kinematic_q  <= cfg_data_i[0];
        rbe_pkg::REG_DRAG_RATE:  drag_q       <= cfg_data_i[rbe_pkg::DRAG_BITS-1:0];
        rbe_pkg::REG_INV_MASS:   inv_mass_q   <= cfg_data_i[rbe_pkg::IM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // drag factor 1 - drag * dt, clamped at zero
  always_comb begin
    drag_ts     = 32'(drag_q) * 32'(time_step_q);
    factor_diff = 33'(FACTOR_ONE) - {1'b0, drag_ts};
    factor_d    = factor_diff[32] ? '0 : factor_diff[rbe_pkg::DF_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_ONE;
    end else begin
      factor_q <= factor_d;
    end
  end

  assign flags_o.gravity_on = gravity_on_q;
  assign flags_o.kinematic  = kinematic_q;
  assign flags_o.drag_on    = (drag_q != '0);
  assign flags_o.mass_zero  = (inv_mass_q == '0);
  assign time_step_o        = time_step_q;
  assign grav_x_o           = grav_x_q;
  assign grav_y_o           = grav_y_q;
  assign grav_scale_o       = grav_scale_q;
  assign inv_mass_o         = inv_mass_q;
  assign factor_o           = factor_q;

endmodule

// File: rtl/rbe_sequencer.sv
`timescale 1ns / 1ps
`include "rigid_body_euler_step_defines.svh"

module rbe_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  rbe_pkg::cfg_flags_t  flags_i,
  input  logic                 out_block_i,
  output rbe_pkg::ctrl_t       ctrl_o
);

  rbe_pkg::seq_state_e           state_q, state_d;
  logic [rbe_pkg::PC_BITS-1:0]   pc_q, pc_d;
  logic [1:0]                    cmd_q, cmd_d;
  rbe_pkg::ucode_t               cw;
  logic                          hold;
  logic                          cond_hit;
  logic                          issue;
  logic                          vec_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbe_pkg::SEQ_IDLE;
      pc_q    <= '0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cmd_q   <= cmd_d;
    end
  end

  always_comb begin
    cw      = rbe_pkg::ucode_word(pc_q);
    hold    = cw.emit && out_block_i;
    vec_cmd = (cmd_q == rbe_pkg::CMD_FORCE) || (cmd_q == rbe_pkg::CMD_IMPULSE);

    unique case (cw.cond)
      rbe_pkg::COND_NEVER:      cond_hit = 1'b0;
      rbe_pkg::COND_TICK:       cond_hit = (cmd_q == rbe_pkg::CMD_TICK);
      rbe_pkg::COND_IGNORE_VEC: cond_hit = flags_i.kinematic || flags_i.mass_zero || !vec_cmd;
      rbe_pkg::COND_KINEMATIC:  cond_hit = flags_i.kinematic;
      rbe_pkg::COND_NO_GRAV:    cond_hit = !flags_i.gravity_on;
      rbe_pkg::COND_NO_DRAG:    cond_hit = !flags_i.drag_on;
      default:                  cond_hit = 1'b0;
    endcase

    state_d = state_q;
    pc_d    = pc_q;
    cmd_d   = cmd_q;
    issue   = 1'b0;
    ctrl_o  = '0;

    unique case (state_q)
      rbe_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = rbe_pkg::SEQ_RUN;
          pc_d        = '0;
          cmd_d       = cmd_i;
        end
      end
      rbe_pkg::SEQ_RUN: begin
        if (!hold) begin
          issue = 1'b1;
          if (cw.last) begin
            state_d = rbe_pkg::SEQ_IDLE;
          end else if (cond_hit) begin
            pc_d = cw.target;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = rbe_pkg::SEQ_IDLE;
      end
    endcase

    if (issue) begin
      ctrl_o.mul_en  = cw.mul_en;
      ctrl_o.src     = cw.src;
      ctrl_o.coef    = cw.coef;
      ctrl_o.wr      = cw.wr;
      ctrl_o.clr_acc = cw.clr_acc;
      ctrl_o.emit    = cw.emit;
      unique case (cw.dst)
        rbe_pkg::DST_VEC_X: ctrl_o.dst = (cmd_q == rbe_pkg::CMD_IMPULSE) ?
                                         rbe_pkg::DST_VEL_X : rbe_pkg::DST_ACC_X;
        rbe_pkg::DST_VEC_Y: ctrl_o.dst = (cmd_q == rbe_pkg::CMD_IMPULSE) ?
                                         rbe_pkg::DST_VEL_Y : rbe_pkg::DST_ACC_Y;
        default:            ctrl_o.dst = cw.dst;
      endcase
    end
  end

  assign in_stall_o = (state_q != rbe_pkg::SEQ_IDLE);

  `RBE_ASSERT_NEXT(a_start_at_entry, ctrl_o.load, state_q == rbe_pkg::SEQ_RUN && pc_q == '0, "sequencer did not start at step zero")
  `RBE_ASSERT_NEXT(a_hold_on_block, state_q == rbe_pkg::SEQ_RUN && cw.emit && out_block_i, state_q == rbe_pkg::SEQ_RUN && pc_q == $past(pc_q), "result step advanced while output was blocked")
  `RBE_ASSERT(a_pc_in_program, state_q == rbe_pkg::SEQ_RUN |-> pc_q <= rbe_pkg::PC_END, "step counter left the program")
  `RBE_ASSERT(a_quiet_when_idle, state_q == rbe_pkg::SEQ_IDLE |-> ctrl_o.wr == rbe_pkg::WR_NONE && !ctrl_o.emit && !ctrl_o.mul_en, "datapath driven while idle")

endmodule

// File: rtl/rbe_datapath.sv
`timescale 1ns / 1ps

module rbe_datapath #(
  parameter int unsigned WORD_BITS = rbe_pkg::WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rbe_pkg::ctrl_t                      ctrl_i,
  input  logic signed [WORD_BITS-1:0]         vec_x_i,
  input  logic signed [WORD_BITS-1:0]         vec_y_i,
  input  logic signed [WORD_BITS-1:0]         grav_x_i,
  input  logic signed [WORD_BITS-1:0]         grav_y_i,
  input  logic signed [rbe_pkg::GS_BITS-1:0]  grav_scale_i,
  input  logic [rbe_pkg::TS_BITS-1:0]         time_step_i,
  input  logic [rbe_pkg::IM_BITS-1:0]         inv_mass_i,
  input  logic [rbe_pkg::DF_BITS-1:0]         factor_i,
  input  logic                                out_stall_i,
  output logic                                out_block_o,
  output logic                                out_valid_o,
  output logic signed [WORD_BITS-1:0]         out_pos_x_o,
  output logic signed [WORD_BITS-1:0]         out_pos_y_o,
  output logic signed [WORD_BITS-1:0]         out_vel_x_o,
  output logic signed [WORD_BITS-1:0]         out_vel_y_o,
  output logic                                saturated_o
);

  localparam int unsigned PROD_BITS = WORD_BITS + rbe_pkg::COEF_BITS;
  localparam int unsigned CB        = rbe_pkg::COEF_BITS;
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic signed [WORD_BITS-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;
  logic signed [WORD_BITS-1:0] vec_x_q, vec_y_q;
  logic signed [WORD_BITS-1:0] prod_q, prod_d;
  logic                        flag_q, flag_d;
  logic                        out_valid_q;
  logic signed [WORD_BITS-1:0] out_pos_x_q, out_pos_y_q, out_vel_x_q, out_vel_y_q;
  logic                        out_sat_q;

  logic signed [WORD_BITS-1:0] mul_a;
  logic signed [CB-1:0]        mul_k;
  logic signed [PROD_BITS-1:0] mul_full, mul_shr;
  logic [PROD_BITS-WORD_BITS:0] mul_hi;
  logic                        mul_sat;
  logic signed [WORD_BITS-1:0] dst_val;
  logic [WORD_BITS:0]          sum;
  logic                        add_ovf;
  logic signed [WORD_BITS-1:0] add_res;
  logic signed [WORD_BITS-1:0] wr_val;

  // shared multiply, floor shift and saturate
  always_comb begin
    case (ctrl_i.src)
      rbe_pkg::SRC_VEC_X:  mul_a = vec_x_q;
      rbe_pkg::SRC_VEC_Y:  mul_a = vec_y_q;
      rbe_pkg::SRC_GRAV_X: mul_a = grav_x_i;
      rbe_pkg::SRC_GRAV_Y: mul_a = grav_y_i;
      rbe_pkg::SRC_ACC_X:  mul_a = acc_x_q;
      rbe_pkg::SRC_ACC_Y:  mul_a = acc_y_q;
      rbe_pkg::SRC_VEL_X:  mul_a = vel_x_q;
      rbe_pkg::SRC_VEL_Y:  mul_a = vel_y_q;
      default:             mul_a = vel_y_q;
    endcase

    case (ctrl_i.coef)
      rbe_pkg::COEF_INV_MASS:
        mul_k = $signed({{(CB-rbe_pkg::IM_BITS){1'b0}}, inv_mass_i});
      rbe_pkg::COEF_GRAV_SCALE:
        mul_k = $signed({{(CB-rbe_pkg::GS_BITS){grav_scale_i[rbe_pkg::GS_BITS-1]}},
                         grav_scale_i});
      rbe_pkg::COEF_TIME_STEP:
        mul_k = $signed({{(CB-rbe_pkg::TS_BITS){1'b0}}, time_step_i});
      default:
        mul_k = $signed({{(CB-rbe_pkg::DF_BITS){1'b0}}, factor_i});
    endcase

    mul_full = PROD_BITS'(mul_a) * PROD_BITS'(mul_k);

    case (ctrl_i.coef)
      rbe_pkg::COEF_INV_MASS:   mul_shr = mul_full >>> rbe_pkg::IM_FRAC;
      rbe_pkg::COEF_GRAV_SCALE: mul_shr = mul_full >>> rbe_pkg::GS_FRAC;
      rbe_pkg::COEF_TIME_STEP:  mul_shr = mul_full >>> rbe_pkg::TS_FRAC;
      default:                  mul_shr = mul_full >>> rbe_pkg::DF_FRAC;
    endcase

    mul_hi  = mul_shr[PROD_BITS-1:WORD_BITS-1];
    mul_sat = !((&mul_hi) || !(|mul_hi));
    if (mul_sat) begin
      prod_d = mul_shr[PROD_BITS-1] ? WORD_MIN : WORD_MAX;
    end else begin
      prod_d = mul_shr[WORD_BITS-1:0];
    end
  end

  // saturating accumulate into, or plain move to, the selected state word
  always_comb begin
    case (ctrl_i.dst)
      rbe_pkg::DST_ACC_X: dst_val = acc_x_q;
      rbe_pkg::DST_ACC_Y: dst_val = acc_y_q;
      rbe_pkg::DST_VEL_X: dst_val = vel_x_q;
      rbe_pkg::DST_VEL_Y: dst_val = vel_y_q;
      rbe_pkg::DST_POS_X: dst_val = pos_x_q;
      rbe_pkg::DST_POS_Y: dst_val = pos_y_q;
      default:            dst_val = '0;
    endcase

    sum     = {dst_val[WORD_BITS-1], dst_val} + {prod_q[WORD_BITS-1], prod_q};
    add_ovf = sum[WORD_BITS] ^ sum[WORD_BITS-1];
    if (add_ovf) begin
      add_res = sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      add_res = sum[WORD_BITS-1:0];
    end

    wr_val = (ctrl_i.wr == rbe_pkg::WR_MOVE) ? prod_q : add_res;

    flag_d = flag_q;
    if (ctrl_i.load) begin
      flag_d = 1'b0;
    end else begin
      flag_d = flag_q || (ctrl_i.mul_en && mul_sat) ||
               (ctrl_i.wr == rbe_pkg::WR_ADD && add_ovf);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      vec_x_q <= vec_x_i;
      vec_y_q <= vec_y_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
      flag_q  <= 1'b0;
    end else begin
      flag_q <= flag_d;
      if (ctrl_i.wr == rbe_pkg::WR_ADD || ctrl_i.wr == rbe_pkg::WR_MOVE) begin
        case (ctrl_i.dst)
          rbe_pkg::DST_ACC_X: acc_x_q <= wr_val;
          rbe_pkg::DST_ACC_Y: acc_y_q <= wr_val;
          rbe_pkg::DST_VEL_X: vel_x_q <= wr_val;
          rbe_pkg::DST_VEL_Y: vel_y_q <= wr_val;
          rbe_pkg::DST_POS_X: pos_x_q <= wr_val;
          rbe_pkg::DST_POS_Y: pos_y_q <= wr_val;
          default: ;
        endcase
      end
      if (ctrl_i.clr_acc) begin
        acc_x_q <= '0;
        acc_y_q <= '0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_pos_x_q <= pos_x_q;
      out_pos_y_q <= pos_y_q;
      out_vel_x_q <= vel_x_q;
      out_vel_y_q <= vel_y_q;
      out_sat_q   <= flag_q;
    end
  end

  assign out_block_o = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_pos_x_o = out_pos_x_q;
  assign out_pos_y_o = out_pos_y_q;
  assign out_vel_x_o = out_vel_x_q;
  assign out_vel_y_o = out_vel_y_q;
  assign saturated_o = out_sat_q;

endmodule

// File: rtl/rigid_body_euler_step.sv
`timescale 1ns / 1ps
// Semi-implicit Euler integrator for one 2D point body in signed fixed point.
// Each input word is a tick, a force or an impulse; only a tick returns a
// result word (position, velocity and a saturation flag). All arithmetic runs
// through one shared multiply-shift-saturate unit and one saturating adder,
// sequenced by a 21-step microprogram, so the block takes one event at a time
// and in_stall_o stays high until it is done. A tick runs the gravity,
// velocity, drag and position steps, skipping gravity or drag when off; a
// kinematic tick goes straight to its result step, and an unused command is
// ignored. The result word sits in an output register, so the next event is
// taken while it waits; a tick reaching its result step holds there while
// that register is still stalled. Registers are written through the
// configuration port, which is always ready, and are meant to be changed only
// while no event is in flight.

module rigid_body_euler_step #(
  parameter int unsigned WORD_BITS     = rbe_pkg::WORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rbe_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       cmd_i,
  input  logic signed [WORD_BITS-1:0]      vec_x_i,
  input  logic signed [WORD_BITS-1:0]      vec_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [WORD_BITS-1:0]      out_pos_x_o,
  output logic signed [WORD_BITS-1:0]      out_pos_y_o,
  output logic signed [WORD_BITS-1:0]      out_vel_x_o,
  output logic signed [WORD_BITS-1:0]      out_vel_y_o,
  output logic                             saturated_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rbe_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]             cfg_data_i
);

  rbe_pkg::cfg_flags_t                flags;
  rbe_pkg::ctrl_t                     ctrl;
  logic [rbe_pkg::TS_BITS-1:0]        time_step;
  logic signed [WORD_BITS-1:0]        grav_x;
  logic signed [WORD_BITS-1:0]        grav_y;
  logic signed [rbe_pkg::GS_BITS-1:0] grav_scale;
  logic [rbe_pkg::IM_BITS-1:0]        inv_mass;
  logic [rbe_pkg::DF_BITS-1:0]        factor;
  logic                               out_block;

  rbe_cfg_regs #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .flags_o      (flags),
    .time_step_o  (time_step),
    .grav_x_o     (grav_x),
    .grav_y_o     (grav_y),
    .grav_scale_o (grav_scale),
    .inv_mass_o   (inv_mass),
    .factor_o     (factor)
  );

  rbe_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .flags_i     (flags),
    .out_block_i (out_block),
    .ctrl_o      (ctrl)
  );

  rbe_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .vec_x_i      (vec_x_i),
    .vec_y_i      (vec_y_i),
    .grav_x_i     (grav_x),
    .grav_y_i     (grav_y),
    .grav_scale_i (grav_scale),
    .time_step_i  (time_step),
    .inv_mass_i   (inv_mass),
    .factor_i     (factor),
    .out_stall_i  (out_stall_i),
    .out_block_o  (out_block),
    .out_valid_o  (out_valid_o),
    .out_pos_x_o  (out_pos_x_o),
    .out_pos_y_o  (out_pos_y_o),
    .out_vel_x_o  (out_vel_x_o),
    .out_vel_y_o  (out_vel_y_o),
    .saturated_o  (saturated_o)
  );

endmodule

// File: tb/tb_rigid_body_euler_step.sv
`timescale 1ns / 1ps

module tb_rigid_body_euler_step;

  localparam int unsigned SETTLE_CYCLES    = 24;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned PHASES           = 20;
  localparam int unsigned EVENTS_PER_PHASE = 82;
  localparam int unsigned DIR_ROWS         = 33;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [3:0]  UNUSED_REG_IDX = 4'd15;
  localparam longint      WORD_MAX       = 64'sd2147483647;
  localparam longint      WORD_MIN       = -64'sd2147483648;
  localparam logic [31:0] POS_FULL       = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_FULL       = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic        sat;
  } body_report_t;

  typedef enum logic [1:0] {
    ROW_EVENT,
    ROW_KNOWN,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [3:0]   reg_idx;
    logic [1:0]   cmd;
    logic [31:0]  vx;
    logic [31:0]  vy;
    logic [31:0]  data;
    body_report_t want;
  } stim_row_t;

  localparam body_report_t NO_REPORT   = '0;
  localparam body_report_t FIRST_DROP  = '{32'd0, 32'd17831, 32'd0, 32'd1070160, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [31:0] vec_x_i;
  logic [31:0] vec_y_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] out_pos_x_o;
  logic [31:0] out_pos_y_o;
  logic [31:0] out_vel_x_o;
  logic [31:0] out_vel_y_o;
  logic        saturated_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // body model
  logic [15:0]        cfg_time_step;
  logic signed [31:0] cfg_grav_x;
  logic signed [31:0] cfg_grav_y;
  logic signed [15:0] cfg_grav_scale;
  bit                 cfg_grav_on;
  bit                 cfg_kinematic;
  logic [15:0]        cfg_drag;
  logic [23:0]        cfg_inv_mass;
  longint             body_pos_x, body_pos_y, body_vel_x, body_vel_y;
  longint             body_acc_x, body_acc_y;
  bit                 step_clamped;

  body_report_t expected_reports[$];

  int unsigned hold_pct, stall_pct, stall_left;
  int unsigned cycle_count;
  int unsigned n_ticks, n_forces, n_impulses, n_unused, n_settings;
  int unsigned n_reports, n_sat_reports, n_errors;
  bit          cfg_active;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_KNOWN, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, FIRST_DROP},
    '{ROW_WRITE, rbe_pkg::REG_KINEMATIC, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd1, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_FORCE, POS_FULL, POS_FULL, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_IMPULSE, NEG_FULL, NEG_FULL, 32'd0, NO_REPORT},
    '{ROW_KNOWN, 4'd0, rbe_pkg::CMD_TICK, ALL_ONES, ALL_ONES, 32'd0, FIRST_DROP},
    '{ROW_EVENT, 4'd0, CMD_UNUSED, ALL_ONES, ALL_ONES, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_KINEMATIC, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_GRAVITY_ON, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_INV_MASS, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_FORCE, POS_FULL, NEG_FULL, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_IMPULSE, 32'd1, ALL_ONES, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, ALL_ONES, ALL_ONES, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_INV_MASS, rbe_pkg::CMD_TICK, 32'd0, 32'd0, ALL_ONES, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_FORCE, POS_FULL, NEG_FULL, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_IMPULSE, NEG_FULL, POS_FULL, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_GRAVITY_ON, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd1, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_GRAVITY_X, rbe_pkg::CMD_TICK, 32'd0, 32'd0, NEG_FULL, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_GRAVITY_Y, rbe_pkg::CMD_TICK, 32'd0, 32'd0, POS_FULL, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_GRAV_SCALE, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'h8000, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_GRAV_SCALE, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'h7FFF, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_TIME_STEP, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'hFFFF, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_DRAG_RATE, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'hFFFF, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_TIME_STEP, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_DRAG_RATE, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd1, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, UNUSED_REG_IDX, rbe_pkg::CMD_TICK, 32'd0, 32'd0, ALL_ONES, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_IMPULSE, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_EVENT, 4'd0, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, NO_REPORT},
    '{ROW_WRITE, rbe_pkg::REG_TIME_STEP, rbe_pkg::CMD_TICK, 32'd0, 32'd0, 32'd1092, NO_REPORT}
  };

  rigid_body_euler_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pos_x_o (out_pos_x_o),
    .out_pos_y_o (out_pos_y_o),
    .out_vel_x_o (out_vel_x_o),
    .out_vel_y_o (out_vel_y_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) begin
      step_clamped = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      step_clamped = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  function automatic longint mul_shift(longint v, longint k, int unsigned frac);
    return clamp_word((v * k) >>> frac);
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0: w = POS_FULL;
      1: w = NEG_FULL;
      2, 3: w = $urandom();
      default: w = 32'($urandom_range(32'h003F_FFFF)) - 32'h0020_0000;
    endcase
    return w;
  endfunction

  task automatic model_event(input logic [1:0] cmd, input logic [31:0] vx, input logic [31:0] vy,
                             output bit emits, output body_report_t rep);
    longint dx, dy, ts, factor;
    emits        = 1'b0;
    rep          = '0;
    step_clamped = 1'b0;
    ts           = longint'(cfg_time_step);
    if (cmd == rbe_pkg::CMD_FORCE || cmd == rbe_pkg::CMD_IMPULSE) begin
      if (!cfg_kinematic && cfg_inv_mass != '0) begin
        dx = mul_shift(longint'($signed(vx)), longint'(cfg_inv_mass), rbe_pkg::IM_FRAC);
        dy = mul_shift(longint'($signed(vy)), longint'(cfg_inv_mass), rbe_pkg::IM_FRAC);
        if (cmd == rbe_pkg::CMD_FORCE) begin
          body_acc_x = clamp_word(body_acc_x + dx);
          body_acc_y = clamp_word(body_acc_y + dy);
        end else begin
          body_vel_x = clamp_word(body_vel_x + dx);
          body_vel_y = clamp_word(body_vel_y + dy);
        end
      end
    end else if (cmd == rbe_pkg::CMD_TICK) begin
      if (!cfg_kinematic) begin
        if (cfg_grav_on) begin
          body_acc_x = clamp_word(body_acc_x + mul_shift(longint'(cfg_grav_x),
                                  longint'(cfg_grav_scale), rbe_pkg::GS_FRAC));
          body_acc_y = clamp_word(body_acc_y + mul_shift(longint'(cfg_grav_y),
                                  longint'(cfg_grav_scale), rbe_pkg::GS_FRAC));
        end
        body_vel_x = clamp_word(body_vel_x + mul_shift(body_acc_x, ts, rbe_pkg::TS_FRAC));
        body_vel_y = clamp_word(body_vel_y + mul_shift(body_acc_y, ts, rbe_pkg::TS_FRAC));
        if (cfg_drag != '0) begin
          factor = (longint'(1) <<< rbe_pkg::DF_FRAC) - longint'(cfg_drag) * ts;
          if (factor < 0) factor = 0;
          body_vel_x = mul_shift(body_vel_x, factor, rbe_pkg::DF_FRAC);
          body_vel_y = mul_shift(body_vel_y, factor, rbe_pkg::DF_FRAC);
        end
        body_pos_x = clamp_word(body_pos_x + mul_shift(body_vel_x, ts, rbe_pkg::TS_FRAC));
        body_pos_y = clamp_word(body_pos_y + mul_shift(body_vel_y, ts, rbe_pkg::TS_FRAC));
        body_acc_x = 0;
        body_acc_y = 0;
      end
      emits     = 1'b1;
      rep.pos_x = body_pos_x[31:0];
      rep.pos_y = body_pos_y[31:0];
      rep.vel_x = body_vel_x[31:0];
      rep.vel_y = body_vel_y[31:0];
      rep.sat   = step_clamped;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rbe_pkg::REG_TIME_STEP:  cfg_time_step  = data[15:0];
      rbe_pkg::REG_GRAVITY_X:  cfg_grav_x     = data;
      rbe_pkg::REG_GRAVITY_Y:  cfg_grav_y     = data;
      rbe_pkg::REG_GRAV_SCALE: cfg_grav_scale = data[15:0];
      rbe_pkg::REG_GRAVITY_ON: cfg_grav_on    = data[0];
      rbe_pkg::REG_KINEMATIC:  cfg_kinematic  = data[0];
      rbe_pkg::REG_DRAG_RATE:  cfg_drag       = data[15:0];
      rbe_pkg::REG_INV_MASS:   cfg_inv_mass   = data[23:0];
      default: ;
    endcase
  endtask

  task automatic send_event(input logic [1:0] cmd, input logic [31:0] vx, input logic [31:0] vy,
                            input bit known, input body_report_t want);
    bit           emits;
    body_report_t rep;
    if (hold_pct != 0 && $urandom_range(99) < hold_pct) begin
      in_valid_i <= 1'b0;
      // drain the block now and then before the next word
      if ($urandom_range(19) == 0) begin
        do @(posedge clk_i); while (expected_reports.size() != 0);
      end else begin
        repeat ($urandom_range(7, 1)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    vec_x_i    <= vx;
    vec_y_i    <= vy;
    do @(posedge clk_i); while (in_stall_o);
    model_event(cmd, vx, vy, emits, rep);
    if (emits) expected_reports.insert(expected_reports.size(), known ? want : rep);
    case (cmd)
      rbe_pkg::CMD_TICK:    n_ticks++;
      rbe_pkg::CMD_FORCE:   n_forces++;
      rbe_pkg::CMD_IMPULSE: n_impulses++;
      default:              n_unused++;
    endcase
  endtask

  always @(posedge clk_i) begin
    body_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual pos %h %h vel %h %h sat %b",
                 $time, out_pos_x_o, out_pos_y_o, out_vel_x_o, out_vel_y_o, saturated_o);
        n_errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("pos_x", want.pos_x, out_pos_x_o);
        check_field("pos_y", want.pos_y, out_pos_y_o);
        check_field("vel_x", want.vel_x, out_vel_x_o);
        check_field("vel_y", want.vel_y, out_vel_y_o);
        check_field("saturated", {31'd0, want.sat}, {31'd0, saturated_o});
        n_reports++;
        if (saturated_o) n_sat_reports++;
      end
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [1:0]  cmd;
    int unsigned r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    vec_x_i     = '0;
    vec_y_i     = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cycle_count = 0;
    stall_left  = 0;
    hold_pct    = 20;
    stall_pct   = 20;
    cfg_active  = 1'b0;

    cfg_time_step  = rbe_pkg::TS_RST;
    cfg_grav_x     = '0;
    cfg_grav_y     = 32'(rbe_pkg::GRAV_Y_UNITS << rbe_pkg::FRACTION_BITS_DEF);
    cfg_grav_scale = rbe_pkg::GS_RST;
    cfg_grav_on    = 1'b1;
    cfg_kinematic  = 1'b0;
    cfg_drag       = '0;
    cfg_inv_mass   = rbe_pkg::IM_RST;
    body_pos_x = 0;  body_pos_y = 0;
    body_vel_x = 0;  body_vel_y = 0;
    body_acc_x = 0;  body_acc_y = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (!cfg_active) begin
          wait_idle();
          n_settings++;
        end
        write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
        cfg_active = 1'b1;
      end else begin
        if (cfg_active) cfg_valid_i <= 1'b0;
        cfg_active = 1'b0;
        send_event(dir_rows[i].cmd, dir_rows[i].vx, dir_rows[i].vy,
                   dir_rows[i].kind == ROW_KNOWN, dir_rows[i].want);
      end
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      n_settings++;
      if (ph >= PHASES - 3) begin
        hold_pct  = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(3))
          0: hold_pct = 0;
          1: hold_pct = 10;
          2: hold_pct = 30;
          default: hold_pct = 60;
        endcase
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      case ($urandom_range(7))
        0: write_reg(rbe_pkg::REG_TIME_STEP, 32'd0);
        1: write_reg(rbe_pkg::REG_TIME_STEP, 32'h0000_FFFF);
        default: write_reg(rbe_pkg::REG_TIME_STEP, $urandom_range(8000, 100));
      endcase
      write_reg(rbe_pkg::REG_GRAVITY_X, pick_word());
      write_reg(rbe_pkg::REG_GRAVITY_Y, pick_word());
      case ($urandom_range(7))
        0: write_reg(rbe_pkg::REG_GRAV_SCALE, 32'h0000_8000);
        1: write_reg(rbe_pkg::REG_GRAV_SCALE, 32'h0000_7FFF);
        default: write_reg(rbe_pkg::REG_GRAV_SCALE,
                           {16'd0, 16'($urandom_range(1023)) - 16'd512});
      endcase
      write_reg(rbe_pkg::REG_GRAVITY_ON, {31'd0, 1'($urandom_range(1))});
      write_reg(rbe_pkg::REG_KINEMATIC, {31'd0, $urandom_range(5) == 0});
      case ($urandom_range(7))
        0, 1, 2: write_reg(rbe_pkg::REG_DRAG_RATE, 32'd0);
        3: write_reg(rbe_pkg::REG_DRAG_RATE, 32'h0000_FFFF);
        default: write_reg(rbe_pkg::REG_DRAG_RATE, $urandom_range(2000, 1));
      endcase
      case ($urandom_range(7))
        0: write_reg(rbe_pkg::REG_INV_MASS, 32'd0);
        1: write_reg(rbe_pkg::REG_INV_MASS, 32'h00FF_FFFF);
        default: write_reg(rbe_pkg::REG_INV_MASS, $urandom_range(32'h0004_0000, 1));
      endcase
      if ($urandom_range(3) == 0)
        write_reg(UNUSED_REG_IDX - 4'($urandom_range(7)), $urandom());
      cfg_valid_i <= 1'b0;

      repeat (EVENTS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 45) cmd = rbe_pkg::CMD_TICK;
        else if (r < 70) cmd = rbe_pkg::CMD_FORCE;
        else if (r < 93) cmd = rbe_pkg::CMD_IMPULSE;
        else cmd = CMD_UNUSED;
        send_event(cmd, pick_word(), pick_word(), 1'b0, NO_REPORT);
      end
    end
    wait_idle();

    $display("Sent %0d ticks, %0d forces, %0d impulses and %0d unused commands over %0d settings.",
             n_ticks, n_forces, n_impulses, n_unused, n_settings);
    $display("Checked %0d reports, %0d with saturation flagged; %0d mismatches.",
             n_reports, n_sat_reports, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
